// ===== src/dwr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dwr_pkg;

    localparam int unsigned MAX_STATES  = 16;
    localparam int unsigned MAX_SYMBOLS = 8;
    localparam int unsigned MAX_LEN     = 32;

    localparam int unsigned STATE_W = 4;
    localparam int unsigned SYM_W   = 3;
    localparam int unsigned ALPHA_W = 4;
    localparam int unsigned COUNT_W = 64;

    typedef enum logic [2:0] {
        CMD_LOAD   = 3'd0,
        CMD_ACCEPT = 3'd1,
        CMD_BUILD  = 3'd2,
        CMD_RANK   = 3'd3,
        CMD_UNRANK = 3'd4
    } cmd_t;

    localparam logic [1:0] REG_WORD_LEN      = 2'd0;
    localparam logic [1:0] REG_ALPHABET_SIZE = 2'd1;
    localparam logic [1:0] REG_STATE_COUNT   = 2'd2;

    typedef struct packed {
        logic [5:0] word_len;
        logic [3:0] alphabet_size;
        logic [4:0] state_count;
    } cfg_t;

    typedef struct packed {
        logic [2:0]          cmd;
        logic [STATE_W-1:0]  state_index;
        logic [SYM_W-1:0]    symbol;
        logic [STATE_W-1:0]  next_state;
        logic                accepting;
        logic                word_end;
        logic [COUNT_W-1:0]  rank_in;
    } in_item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] rank;
        logic [SYM_W-1:0]   symbol;
        logic               last;
        logic               error;
    } result_t;

endpackage

`default_nettype wire

// ===== src/dfa_word_rank_unrank.sv =====
`timescale 1ns / 1ps
`default_nettype none
// DFA word rank / unrank engine, start state 0.
// Input channel (s_*): one word per command. Load-transition and set-accepting
//   words finish with no result. Build fills the count table and returns the word
//   count (max rank + 1); rank words stream a word's symbols and return its rank on
//   word_end; unrank returns n symbol words, last on the nth, else one error word.
// Result channel (m_*): registered output stage; the engine can finish its
//   next result while one waits, and holds only when both are full.
// Throughput: one command at a time. Each counted symbol takes one read of the
//   transition RAM port; its count read is issued from pipeline stage 1 and its
//   data lands in stage 2. Each table has a single read port.
// Configuration (cfg_*): writes are registered, values clamped to range;
//   write only while idle.
// Reset: aresetn synchronous, active low; accepting flags, rank stream state
//   and config return to defaults. Tables are not cleared; build fills the
//   count table before use.

module dfa_word_rank_unrank import dwr_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [5:0]   cfg_wdata,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic [2:0]   s_cmd,
    input  wire logic [3:0]   s_state_index,
    input  wire logic [2:0]   s_symbol,
    input  wire logic [3:0]   s_next_state,
    input  wire logic         s_accepting,
    input  wire logic         s_word_end,
    input  wire logic [63:0]  s_rank_in,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic [63:0]       m_rank_out,
    output logic [2:0]        m_symbol_out,
    output logic              m_last,
    output logic              m_error
);

    localparam logic [3:0] ALPHA_RST = (MAX_SYMBOLS < 2) ? 4'd1 : 4'd2;

    cfg_t     cfg_reg;
    in_item_t in_item;
    result_t  res, out_reg;
    logic     res_valid, res_ready, out_valid_reg;

    // clamped register values
    logic [5:0] wl_next;
    logic [3:0] as_next;
    logic [4:0] sc_next;

    always_comb begin
        wl_next = (cfg_wdata == 6'd0) ? 6'd1 :
                  (32'(cfg_wdata) > MAX_LEN) ? 6'(MAX_LEN) : cfg_wdata;
        as_next = (cfg_wdata[3:0] == 4'd0) ? 4'd1 :
                  (32'(cfg_wdata[3:0]) > MAX_SYMBOLS) ? 4'(MAX_SYMBOLS) : cfg_wdata[3:0];
        sc_next = (cfg_wdata[4:0] == 5'd0) ? 5'd1 :
                  (32'(cfg_wdata[4:0]) > MAX_STATES) ? 5'(MAX_STATES) : cfg_wdata[4:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{word_len: 6'd1, alphabet_size: ALPHA_RST, state_count: 5'd1};
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_WORD_LEN:      cfg_reg.word_len      <= wl_next;
                REG_ALPHABET_SIZE: cfg_reg.alphabet_size <= as_next;
                REG_STATE_COUNT:   cfg_reg.state_count   <= sc_next;
                default: ;
            endcase
        end
    end

    assign in_item = '{cmd: s_cmd, state_index: s_state_index, symbol: s_symbol,
                       next_state: s_next_state, accepting: s_accepting,
                       word_end: s_word_end, rank_in: s_rank_in};

    dwr_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_item   (in_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output register: a held result blocks the engine only at its own emit
    assign res_ready = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_ready) begin
            out_valid_reg <= res_valid;
        end
        if (res_ready && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_rank_out   = out_reg.rank;
    assign m_symbol_out = out_reg.symbol;
    assign m_last       = out_reg.last;
    assign m_error      = out_reg.error;

endmodule

`default_nettype wire

// ===== src/dwr_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dwr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned ADDR_W = 4
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [2**ADDR_W];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== src/dwr_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dwr_engine import dwr_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire cfg_t     cfg,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire in_item_t in_item,
    output logic          res_valid,
    input  wire logic     res_ready,
    output result_t       res
);

    localparam int unsigned SW = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
    localparam int unsigned CW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
    localparam int unsigned LW = $clog2(MAX_LEN + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_INIT, S_SWEEP, S_DRAIN, S_MAXRD, S_MAXCMP, S_EMIT
    } fsm_t;

    typedef enum logic [1:0] {
        OP_BUILD, OP_RANK, OP_UNRANK
    } op_t;

    fsm_t state_reg;
    op_t  op_reg;

    logic [STATE_W-1:0] q_reg;
    logic [LW-1:0]      len_reg;
    logic [ALPHA_W-1:0] cnt_reg;
    logic [ALPHA_W-1:0] lim_reg;
    logic [SYM_W-1:0]   sym_reg;
    logic               wend_reg;
    logic [SW-1:0]      init_reg;
    logic [MAX_STATES-1:0] acc_flags_reg;
    logic [4:0]         built_states_reg;
    logic [LW-1:0]      built_len_reg;
    logic [COUNT_W-1:0] sum_reg;
    logic [COUNT_W-1:0] r_reg;
    result_t            res_reg;

    // rank stream state
    logic [STATE_W-1:0] cur_state_reg;
    logic [COUNT_W-1:0] rank_acc_reg;
    logic [LW-1:0]      pos_reg;

    // read pipeline: stage 1 has transition data, stage 2 has count data
    logic               p1_valid_reg, p1_last_reg, p1_inr_reg;
    logic [ALPHA_W-1:0] p1_c_reg;
    logic               p2_valid_reg, p2_last_reg, p2_ok_reg;
    logic [ALPHA_W-1:0] p2_c_reg;
    logic [STATE_W-1:0] p2_t_reg;

    logic [LW-1:0]      n;
    logic [ALPHA_W-1:0] a;
    logic [ALPHA_W-1:0] issue_c;
    logic               issue_last;
    logic               issue_inr;
    logic [STATE_W-1:0] t1;
    logic               ok1;
    logic [COUNT_W-1:0] v;
    logic [COUNT_W-1:0] sum_all;
    logic [COUNT_W-1:0] mx;
    logic               in_fire;

    logic               trans_we;
    logic [SW+CW-1:0]   trans_waddr, trans_raddr;
    logic [STATE_W-1:0] trans_rd;
    logic               count_we;
    logic [SW+LW-1:0]   count_waddr, count_raddr;
    logic [COUNT_W-1:0] count_wdata, count_rd;

    assign n         = LW'(cfg.word_len);
    assign a         = cfg.alphabet_size;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign res_valid = (state_reg == S_EMIT);
    assign res       = res_reg;

    assign issue_last = (cnt_reg == lim_reg);
    assign issue_c    = (op_reg == OP_RANK && issue_last) ? {1'b0, sym_reg} : cnt_reg;
    assign issue_inr  = (32'(q_reg) < MAX_STATES) && (32'(issue_c) < MAX_SYMBOLS);
    assign trans_raddr = {SW'(q_reg), CW'(issue_c)};

    assign t1  = p1_inr_reg ? trans_rd : '0;
    // rows above the built states and lengths past the built level read as zero
    assign ok1 = (32'(t1) < MAX_STATES) &&
                 ((len_reg == '0) ||
                  (({1'b0, t1} < built_states_reg) && (len_reg <= built_len_reg)));
    assign count_raddr = (state_reg == S_MAXRD) ? {{SW{1'b0}}, n} : {SW'(t1), len_reg};

    assign v       = p2_ok_reg ? count_rd : '0;
    assign sum_all = sum_reg + v;
    assign mx      = (n <= built_len_reg) ? count_rd : '0;

    assign trans_we = in_fire && (in_item.cmd == CMD_LOAD) &&
                      (32'(in_item.state_index) < MAX_STATES) &&
                      (32'(in_item.symbol) < MAX_SYMBOLS);
    assign trans_waddr = {SW'(in_item.state_index), CW'(in_item.symbol)};

    always_comb begin
        count_we    = 1'b0;
        count_waddr = {SW'(q_reg), len_reg + LW'(1)};
        count_wdata = sum_all;
        if (state_reg == S_INIT) begin
            count_we    = 1'b1;
            count_waddr = {init_reg, {LW{1'b0}}};
            count_wdata = {{(COUNT_W-1){1'b0}}, acc_flags_reg[init_reg]};
        end else if (p2_valid_reg && p2_last_reg && op_reg == OP_BUILD) begin
            count_we = 1'b1;
        end
    end

    dwr_ram #(.WIDTH(STATE_W), .ADDR_W(SW + CW)) u_trans (
        .aclk  (aclk),
        .we    (trans_we),
        .waddr (trans_waddr),
        .wdata (in_item.next_state),
        .raddr (trans_raddr),
        .rdata (trans_rd)
    );

    dwr_ram #(.WIDTH(COUNT_W), .ADDR_W(SW + LW)) u_count (
        .aclk  (aclk),
        .we    (count_we),
        .waddr (count_waddr),
        .wdata (count_wdata),
        .raddr (count_raddr),
        .rdata (count_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            op_reg           <= OP_BUILD;
            acc_flags_reg    <= '0;
            built_states_reg <= 5'd1;
            built_len_reg    <= '0;
            cur_state_reg    <= '0;
            rank_acc_reg     <= '0;
            pos_reg          <= '0;
            p1_valid_reg     <= 1'b0;
            p2_valid_reg     <= 1'b0;
        end else begin
            // pipeline advance
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= p1_valid_reg;
            p2_c_reg     <= p1_c_reg;
            p2_last_reg  <= p1_last_reg;
            p2_t_reg     <= t1;
            p2_ok_reg    <= ok1;

            unique case (state_reg)
                S_IDLE: begin
                    if (in_fire) begin
                        unique case (cmd_t'(in_item.cmd))
                            CMD_ACCEPT: begin
                                if (32'(in_item.state_index) < MAX_STATES) begin
                                    acc_flags_reg[SW'(in_item.state_index)] <=
                                        in_item.accepting;
                                end
                            end
                            CMD_BUILD: begin
                                op_reg           <= OP_BUILD;
                                init_reg         <= '0;
                                built_states_reg <= cfg.state_count;
                                built_len_reg    <= '0;
                                cur_state_reg    <= '0;
                                rank_acc_reg     <= '0;
                                pos_reg          <= '0;
                                state_reg        <= S_INIT;
                            end
                            CMD_RANK: begin
                                op_reg   <= OP_RANK;
                                q_reg    <= cur_state_reg;
                                sym_reg  <= in_item.symbol;
                                wend_reg <= in_item.word_end;
                                cnt_reg  <= '0;
                                len_reg  <= n - pos_reg - LW'(1);
                                if (pos_reg < n) begin
                                    lim_reg <= ({1'b0, in_item.symbol} < a) ?
                                               {1'b0, in_item.symbol} : a;
                                end else begin
                                    lim_reg <= '0;
                                end
                                state_reg <= S_SWEEP;
                            end
                            CMD_UNRANK: begin
                                op_reg    <= OP_UNRANK;
                                r_reg     <= in_item.rank_in;
                                state_reg <= S_MAXRD;
                            end
                            default: ;
                        endcase
                    end
                end
                S_INIT: begin
                    init_reg <= init_reg + SW'(1);
                    if (32'(init_reg) == MAX_STATES - 1) begin
                        q_reg     <= '0;
                        len_reg   <= '0;
                        cnt_reg   <= '0;
                        lim_reg   <= a - ALPHA_W'(1);
                        sum_reg   <= '0;
                        state_reg <= S_SWEEP;
                    end
                end
                S_SWEEP: begin
                    p1_valid_reg <= 1'b1;
                    p1_c_reg     <= issue_c;
                    p1_last_reg  <= issue_last;
                    p1_inr_reg   <= issue_inr;
                    cnt_reg      <= cnt_reg + ALPHA_W'(1);
                    if (issue_last) begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN: ;
                S_MAXRD: begin
                    state_reg <= S_MAXCMP;
                end
                S_MAXCMP: begin
                    if (op_reg == OP_BUILD) begin
                        res_reg   <= '{rank: mx, symbol: '0, last: 1'b1, error: 1'b0};
                        state_reg <= S_EMIT;
                    end else if (r_reg >= mx) begin
                        res_reg   <= '{rank: '0, symbol: '0, last: 1'b1, error: 1'b1};
                        state_reg <= S_EMIT;
                    end else begin
                        q_reg     <= '0;
                        len_reg   <= n - LW'(1);
                        cnt_reg   <= '0;
                        lim_reg   <= a - ALPHA_W'(1);
                        state_reg <= S_SWEEP;
                    end
                end
                S_EMIT: begin
                    if (res_ready) begin
                        if (op_reg == OP_UNRANK && !res_reg.error && len_reg != '0) begin
                            len_reg   <= len_reg - LW'(1);
                            cnt_reg   <= '0;
                            state_reg <= S_SWEEP;
                        end else begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase

            // count data consumer
            if (p2_valid_reg) begin
                case (op_reg)
                    OP_BUILD: begin
                        sum_reg <= sum_all;
                        if (p2_last_reg) begin
                            sum_reg <= '0;
                            cnt_reg <= '0;
                            if ({1'b0, q_reg} + 5'd1 < built_states_reg) begin
                                q_reg     <= q_reg + STATE_W'(1);
                                state_reg <= S_SWEEP;
                            end else begin
                                q_reg         <= '0;
                                built_len_reg <= len_reg + LW'(1);
                                if (len_reg + LW'(1) < n) begin
                                    len_reg   <= len_reg + LW'(1);
                                    state_reg <= S_SWEEP;
                                end else begin
                                    state_reg <= S_MAXRD;
                                end
                            end
                        end
                    end
                    OP_RANK: begin
                        if (!p2_last_reg) begin
                            rank_acc_reg <= rank_acc_reg + v;
                        end else begin
                            cur_state_reg <= p2_t_reg;
                            if (32'(pos_reg) < MAX_LEN) begin
                                pos_reg <= pos_reg + LW'(1);
                            end
                            if (wend_reg) begin
                                res_reg <= '{rank: rank_acc_reg, symbol: '0,
                                             last: 1'b1, error: 1'b0};
                                cur_state_reg <= '0;
                                rank_acc_reg  <= '0;
                                pos_reg       <= '0;
                                state_reg     <= S_EMIT;
                            end else begin
                                state_reg <= S_IDLE;
                            end
                        end
                    end
                    OP_UNRANK: begin
                        if (r_reg < v || p2_last_reg) begin
                            if (!(r_reg < v)) begin
                                r_reg <= r_reg - v;
                            end
                            res_reg <= '{rank: '0, symbol: SYM_W'(p2_c_reg),
                                         last: (len_reg == '0), error: 1'b0};
                            q_reg        <= p2_t_reg;
                            p1_valid_reg <= 1'b0;
                            p2_valid_reg <= 1'b0;
                            state_reg    <= S_EMIT;
                        end else begin
                            r_reg <= r_reg - v;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// ===== dv/dfa_word_rank_unrank_test.sv =====
`timescale 1ns / 1ps

module dfa_word_rank_unrank_test import dwr_pkg::*; ();

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int DRAIN_CYCLES = 200;
    localparam int RANDOM_WORDS = 260;

    // one row of the directed table; typed rows carry a hand-written result
    typedef struct {
        cmd_t        cmd;
        logic [3:0]  state_index;
        logic [2:0]  symbol;
        logic [3:0]  next_state;
        logic        accepting;
        logic        word_end;
        logic [63:0] rank_in;
        bit          typed;
        logic [63:0] typed_rank;
        logic        typed_error;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = REG_WORD_LEN;
    logic [5:0]  cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_cmd = CMD_LOAD;
    logic [3:0]  s_state_index = '0;
    logic [2:0]  s_symbol = '0;
    logic [3:0]  s_next_state = '0;
    logic        s_accepting = 1'b0;
    logic        s_word_end = 1'b0;
    logic [63:0] s_rank_in = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_rank_out;
    logic [2:0]  m_symbol_out;
    logic        m_last;
    logic        m_error;

    dfa_word_rank_unrank i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_state_index(s_state_index),
        .s_symbol     (s_symbol),
        .s_next_state (s_next_state),
        .s_accepting  (s_accepting),
        .s_word_end   (s_word_end),
        .s_rank_in    (s_rank_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_rank_out   (m_rank_out),
        .m_symbol_out (m_symbol_out),
        .m_last       (m_last),
        .m_error      (m_error)
    );

    always #4 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Shadow of the automaton: transitions, accepting flags, count table,
    // rank stream state and the three config values.
    // ------------------------------------------------------------------
    logic [3:0]  dfa_next [128];
    bit          dfa_accept [16];
    logic [63:0] word_count [16][33];
    logic [3:0]  walk_state;
    logic [63:0] rank_sum;
    int unsigned walk_pos;
    int unsigned len_n;
    int unsigned alpha_n;
    int unsigned states_n;

    result_t     expected_results[$];
    int          mismatches = 0;
    int          cycle_count = 0;
    int          idle_mode = 1;     // 0: no idling on either side

    function automatic logic [63:0] count_at(int unsigned s, int unsigned len);
        if (s >= 16 || len > 32) return '0;
        return word_count[s][len];
    endfunction

    function automatic int unsigned clamp_reg(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void push_result(logic [63:0] r, logic [2:0] sym, logic lst,
                                        logic err);
        result_t res;
        res.rank = r;
        res.symbol = sym;
        res.last = lst;
        res.error = err;
        expected_results.push_back(res);
    endfunction

    // apply one accepted word to the shadow and queue what it produces
    function automatic void predict_word(logic [2:0] cmd, logic [3:0] si, logic [2:0] sym,
                                         logic [3:0] nx, logic acc, logic wend,
                                         logic [63:0] r);
        logic [63:0] total;
        logic [63:0] v;
        logic [63:0] left;
        int unsigned lim;
        int unsigned pick;
        logic [3:0]  q;
        case (cmd)
            CMD_LOAD: begin
                dfa_next[si * 8 + sym] = nx;
            end
            CMD_ACCEPT: begin
                dfa_accept[si] = acc;
            end
            CMD_BUILD: begin
                for (int s = 0; s < 16; s++)
                    for (int l = 0; l <= 32; l++)
                        word_count[s][l] = (l == 0) ? 64'(dfa_accept[s]) : '0;
                for (int i = 0; i < len_n; i++)
                    for (int s = 0; s < states_n; s++) begin
                        total = '0;
                        for (int c = 0; c < alpha_n; c++)
                            total += count_at(dfa_next[s * 8 + c], i);
                        word_count[s][i + 1] = total;
                    end
                walk_state = '0;
                rank_sum = '0;
                walk_pos = 0;
                push_result(count_at(0, len_n), '0, 1'b1, 1'b0);
            end
            CMD_RANK: begin
                if (walk_pos < len_n) begin
                    lim = (sym < alpha_n) ? sym : alpha_n;
                    for (int c = 0; c < lim; c++)
                        rank_sum += count_at(dfa_next[walk_state * 8 + c],
                                             len_n - walk_pos - 1);
                end
                walk_state = dfa_next[walk_state * 8 + sym];
                if (walk_pos < 32) walk_pos++;
                if (wend) begin
                    push_result(rank_sum, '0, 1'b1, 1'b0);
                    walk_state = '0;
                    rank_sum = '0;
                    walk_pos = 0;
                end
            end
            CMD_UNRANK: begin
                left = r;
                q = '0;
                if (left >= count_at(0, len_n)) begin
                    push_result('0, '0, 1'b1, 1'b1);
                end else begin
                    for (int i = 1; i <= len_n; i++) begin
                        pick = alpha_n - 1;
                        for (int c = 0; c < alpha_n; c++) begin
                            v = count_at(dfa_next[q * 8 + c], len_n - i);
                            if (left < v) begin
                                pick = c;
                                break;
                            end
                            left -= v;
                        end
                        push_result('0, pick[2:0], (i == len_n), 1'b0);
                        q = dfa_next[q * 8 + pick];
                    end
                end
            end
            default: ;  // unused codes do nothing
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Idling: mode flips now and then; mode 0 is a stretch with no gaps.
    // ------------------------------------------------------------------
    function automatic int gap_len();
        int p;
        if (idle_mode == 0) return 0;
        p = $urandom_range(99);
        if (p < 45) return 0;
        if (p < 85) return $urandom_range(3, 1);
        if (p < 96) return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    always @(posedge aclk) begin
        if ($urandom_range(299) == 0) idle_mode <= $urandom_range(3);
        if (idle_mode == 0) m_ready <= 1'b1;
        else if ($urandom_range(99) < 3) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(99) < 70);
    end

    // result checker
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: rank %h sym %0d last %0b err %0b",
                             m_rank_out, m_symbol_out, m_last, m_error);
            end else begin
                want = expected_results.pop_front();
                if (want.rank !== m_rank_out || want.symbol !== m_symbol_out ||
                    want.last !== m_last || want.error !== m_error) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp rank %h sym %0d last %0b err %0b,",
                                 want.rank, want.symbol, want.last, want.error,
                                 " got rank %h sym %0d last %0b err %0b",
                                 m_rank_out, m_symbol_out, m_last, m_error);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("dfa_word_rank_unrank_test: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sender; valid stays up across back-to-back words.
    // ------------------------------------------------------------------
    task automatic send_word(logic [2:0] cmd, logic [3:0] si, logic [2:0] sym,
                             logic [3:0] nx, logic acc, logic wend, logic [63:0] r);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_state_index <= si;
        s_symbol <= sym;
        s_next_state <= nx;
        s_accepting <= acc;
        s_word_end <= wend;
        s_rank_in <= r;
        do @(posedge aclk); while (!s_ready);
        predict_word(cmd, si, sym, nx, acc, wend, r);
    endtask

    // hold off until every result is back, then let loads settle
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_config(int unsigned wl, int unsigned asz, int unsigned sc);
        drain_results();
        cfg_we <= 1'b1;
        cfg_index <= REG_WORD_LEN;
        cfg_wdata <= wl[5:0];
        @(posedge aclk);
        cfg_index <= REG_ALPHABET_SIZE;
        cfg_wdata <= asz[5:0];
        @(posedge aclk);
        cfg_index <= REG_STATE_COUNT;
        cfg_wdata <= sc[5:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        len_n = clamp_reg(wl & 63, 32);
        alpha_n = clamp_reg(asz & 15, 8);
        states_n = clamp_reg(sc & 31, 16);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    stim_row_t directed[$];

    function automatic void add_row(cmd_t cmd, logic [3:0] si, logic [2:0] sym,
                                    logic [3:0] nx, logic acc, logic wend,
                                    logic [63:0] r, bit typed = 0,
                                    logic [63:0] t_rank = '0, logic t_err = 1'b0);
        stim_row_t row;
        row.cmd = cmd;
        row.state_index = si;
        row.symbol = sym;
        row.next_state = nx;
        row.accepting = acc;
        row.word_end = wend;
        row.rank_in = r;
        row.typed = typed;
        row.typed_rank = t_rank;
        row.typed_error = t_err;
        directed.push_back(row);
    endfunction

    initial begin
        int          sent;
        int          phase;
        int          p;
        int          wlen;
        logic [63:0] top;
        logic [63:0] r;
        logic [2:0]  sym;
        int unsigned cfg_plan[8][3] = '{
            '{32, 8, 16}, '{1, 1, 1}, '{0, 0, 0}, '{63, 15, 31},
            '{3, 2, 4}, '{5, 3, 6}, '{2, 8, 16}, '{32, 2, 2}};

        for (int i = 0; i < 128; i++) dfa_next[i] = '0;
        for (int s = 0; s < 16; s++) begin
            dfa_accept[s] = 0;
            for (int l = 0; l <= 32; l++) word_count[s][l] = '0;
        end
        walk_state = '0;
        rank_sum = '0;
        walk_pos = 0;
        len_n = 1;
        alpha_n = 2;
        states_n = 1;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // fill the whole transition table so no later read hits a blank entry
        for (int i = 0; i < 128; i++)
            send_word(CMD_LOAD, i / 8, i % 8, $urandom_range(15), 1'b0, 1'b0, rand64());

        // directed part, defaults n=1, two symbols, one state
        add_row(CMD_BUILD, 0, 0, 0, 0, 0, '0, 1, 64'd0, 1'b0);      // nothing accepts
        add_row(CMD_UNRANK, 0, 0, 0, 0, 0, '0, 1, 64'd0, 1'b1);     // empty language
        add_row(CMD_LOAD, 0, 0, 0, 0, 0, '0);
        add_row(CMD_LOAD, 0, 1, 4'd15, 0, 0, '0);
        add_row(CMD_ACCEPT, 0, 0, 0, 1, 0, '0);
        add_row(CMD_ACCEPT, 4'd15, 0, 0, 1, 0, '0);
        add_row(CMD_BUILD, 0, 0, 0, 0, 0, '0, 1, 64'd2, 1'b0);
        add_row(CMD_UNRANK, 0, 0, 0, 0, 0, 64'd2, 1, 64'd0, 1'b1);  // one past the maximum rank
        add_row(CMD_UNRANK, 0, 0, 0, 0, 0, '1, 1, 64'd0, 1'b1);
        add_row(CMD_UNRANK, 0, 0, 0, 0, 0, 64'd0);
        add_row(CMD_UNRANK, 0, 0, 0, 0, 0, 64'd1);
        add_row(CMD_RANK, 0, 0, 0, 0, 1, '0);
        add_row(CMD_RANK, 0, 1, 0, 0, 1, '0);
        add_row(CMD_RANK, 0, 3'd7, 0, 0, 1, '0);                   // symbol past alphabet
        add_row(CMD_RANK, 0, 1, 0, 0, 0, '0);
        add_row(CMD_RANK, 0, 3'd5, 0, 0, 1, '0);                   // beyond word length
        add_row(cmd_t'(3'd5), 0, 0, 0, 0, 1, '1);
        add_row(cmd_t'(3'd6), 4'd15, 3'd7, 4'd15, 1, 1, '1);
        add_row(cmd_t'(3'd7), 0, 0, 0, 0, 0, '0);
        add_row(CMD_ACCEPT, 4'd15, 0, 0, 0, 0, '0);
        add_row(CMD_BUILD, 0, 0, 0, 0, 0, '0, 1, 64'd1, 1'b0);
        add_row(CMD_LOAD, 4'd15, 3'd7, 4'd15, 0, 0, '0);
        add_row(CMD_RANK, 0, 1, 0, 0, 1, '0);

        foreach (directed[k]) begin
            send_word(directed[k].cmd, directed[k].state_index, directed[k].symbol,
                      directed[k].next_state, directed[k].accepting, directed[k].word_end,
                      directed[k].rank_in);
            if (directed[k].typed) begin
                void'(expected_results.pop_back());
                push_result(directed[k].typed_rank, '0, 1'b1, directed[k].typed_error);
            end
        end

        // random phases, each with its own config
        sent = 0;
        phase = 0;
        while (sent < RANDOM_WORDS) begin
            if (phase < 8)
                write_config(cfg_plan[phase][0], cfg_plan[phase][1], cfg_plan[phase][2]);
            else if ($urandom_range(3) == 0)
                write_config($urandom_range(63), $urandom_range(15), $urandom_range(31));
            else
                write_config($urandom_range(6, 1), $urandom_range(4, 1),
                             $urandom_range(5, 1));
            // long words only in the few large phases
            for (int k = 0; k < 6; k++) begin
                send_word(CMD_LOAD, $urandom_range(states_n - 1), $urandom_range(7),
                          $urandom_range(states_n - 1), 1'b0, 1'b0, rand64());
                sent++;
            end
            for (int s = 0; s < states_n && s < 6; s++) begin
                send_word(CMD_ACCEPT, s, $urandom_range(7), $urandom_range(15),
                          $urandom_range(1), 1'b0, rand64());
                sent++;
            end
            send_word(CMD_BUILD, $urandom_range(15), $urandom_range(7), $urandom_range(15),
                      $urandom_range(1), $urandom_range(1), rand64());
            sent++;
            for (int k = 0; k < ((len_n > 8) ? 4 : 14); k++) begin
                p = $urandom_range(99);
                if (p < 50) begin
                    // well-formed word, sometimes cut short or run long
                    wlen = len_n;
                    if ($urandom_range(9) == 0) wlen = $urandom_range(len_n + 3, 1);
                    for (int j = 0; j < wlen; j++) begin
                        sym = ($urandom_range(9) == 0) ? $urandom_range(7)
                                                        : $urandom_range(alpha_n - 1);
                        send_word(CMD_RANK, $urandom_range(15), sym, $urandom_range(15),
                                  $urandom_range(1), (j == wlen - 1), rand64());
                        sent++;
                    end
                end else if (p < 80) begin
                    top = count_at(0, len_n);
                    p = $urandom_range(9);
                    if (top != 0 && p < 7) r = rand64() % top;
                    else if (top != 0 && p == 7) r = top - 1;
                    else if (p == 8) r = top;
                    else r = rand64();
                    send_word(CMD_UNRANK, $urandom_range(15), $urandom_range(7),
                              $urandom_range(15), $urandom_range(1), $urandom_range(1), r);
                    sent++;
                end else if (p < 88) begin
                    send_word(CMD_LOAD, $urandom_range(15), $urandom_range(7),
                              $urandom_range(15), $urandom_range(1), $urandom_range(1),
                              rand64());
                    sent++;
                end else if (p < 93) begin
                    send_word(CMD_ACCEPT, $urandom_range(15), $urandom_range(7),
                              $urandom_range(15), $urandom_range(1), $urandom_range(1),
                              rand64());
                    sent++;
                end else if (p < 97) begin
                    send_word(cmd_t'($urandom_range(7, 5)), $urandom_range(15),
                              $urandom_range(7), $urandom_range(15), $urandom_range(1),
                              $urandom_range(1), rand64());
                    sent++;
                end else begin
                    send_word(CMD_BUILD, $urandom_range(15), $urandom_range(7),
                              $urandom_range(15), $urandom_range(1), $urandom_range(1),
                              rand64());
                    sent++;
                end
                // sender waits for the block to go quiet now and then
                if ($urandom_range(19) == 0) drain_results();
            end
            phase++;
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("dfa_word_rank_unrank_test: done, clean");
        end else begin
            $display("dfa_word_rank_unrank_test: done, errors");
        end
        $finish;
    end

endmodule

// ===== dfa_word_rank_unrank.f =====
src/dwr_pkg.sv
src/dwr_ram.sv
src/dwr_engine.sv
src/dfa_word_rank_unrank.sv
dv/dfa_word_rank_unrank_test.sv
